### design/elrp_pkg.sv
//------------------------------------------------------------------------------
// elrp_pkg
// Shared types and constants of the exact logrank rejection probability block.
//------------------------------------------------------------------------------
package elrp_pkg;
    localparam int CRIT_W = 20;
    localparam int HR_W   = 24;
    localparam int CNT_W  = 16;
    localparam int EVT_W  = 5;
    localparam int PROB_W = 32;
    localparam int ACC_W  = 31;   // signed Q6.24
    localparam int DIV_W  = 41;   // widest dividend / divisor (hr*T + C<<16)

    typedef enum logic [1:0] {
        REG_CRIT = 2'd0,
        REG_HR   = 2'd1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ORD, ST_EVT, ST_P_WAIT, ST_F_START, ST_F_WAIT,
        ST_MUL, ST_NEXT, ST_CMP1, ST_CMP2, ST_CMP3, ST_ACC, ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [5:0]       frac_bits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PROB_W:0]  quo;
    } t_div_rsp;
endpackage

### design/elrp_if.sv
//------------------------------------------------------------------------------
// elrp_if
// Valid/ready channel interfaces for items, results and configuration writes.
//------------------------------------------------------------------------------
interface elrp_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  event_count;
    logic [15:0] control_size;
    logic [15:0] treatment_size;
    modport source (output valid, event_count, control_size, treatment_size, input ready);
    modport sink   (input valid, event_count, control_size, treatment_size, output ready);
endinterface

interface elrp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] reject_probability;
    logic        bad_arguments;
    modport source (output valid, reject_probability, bad_arguments, input ready);
    modport sink   (input valid, reject_probability, bad_arguments, output ready);
endinterface

interface elrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/elrp_div.sv
//------------------------------------------------------------------------------
// elrp_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^frac / den).
//------------------------------------------------------------------------------
module elrp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  elrp_pkg::t_div_req  i_req,
    output elrp_pkg::t_div_rsp  o_rsp
);
    localparam int W = elrp_pkg::DIV_W;
    localparam int Q = elrp_pkg::PROB_W + 1;

    logic [W:0]   r_rem, n_rem;
    logic [W-1:0] r_den;
    logic [Q-1:0] r_quo, n_quo;
    logic [5:0]   r_cnt;
    logic         r_busy, r_done;
    logic [W:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[W-1:0], 1'b0};
        n_rem = w_sh;
        n_quo = {r_quo[Q-2:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.frac_bits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

### design/exact_logrank_rejection_prob.sv
//------------------------------------------------------------------------------
// exact_logrank_rejection_prob
// Exact logrank rejection probability over all event orderings.
//------------------------------------------------------------------------------
// channel   dir  payload
// s_in      in   event_count, control_size, treatment_size
// m_out     out  reject_probability, bad_arguments
// s_cfg     in   index (0 crit, 1 hazard ratio), data
// Each event step runs the shared divider twice (24 then 32 quotient bits)
// plus a few multiply steps, and an ordering that dies stops at that event.
// Bad arguments go straight to the result. Reset is synchronous and clears
// control. The input is not ready from acceptance until the result is taken.
//------------------------------------------------------------------------------
module exact_logrank_rejection_prob #(
    parameter int MAX_EVENTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    elrp_in_if.sink    s_in,
    elrp_out_if.source m_out,
    elrp_cfg_if.sink   s_cfg
);
    localparam int OW = MAX_EVENTS + 1;  // ordering counter width

    elrp_pkg::t_state   r_st, n_st;
    elrp_pkg::t_div_req w_req;
    elrp_pkg::t_div_rsp w_rsp;

    logic signed [19:0] r_crit;
    logic [23:0]        r_hr;
    logic [4:0]         r_ev;
    logic [15:0]        r_n0, r_n1, r_t, r_c;
    logic [OW-1:0]      r_ord;
    logic [4:0]         r_k;
    logic signed [30:0] r_num;
    logic [30:0]        r_den;
    logic [32:0]        r_prob;
    logic [24:0]        r_p;
    logic [64:0]        r_mul;
    logic [49:0]        r_acc;
    logic               r_alive, r_bad, r_vld, r_gt;
    logic [70:0]        r_lhs;
    logic [39:0]        r_c2;
    logic [70:0]        r_rhs;

    logic               w_bit, w_in_acc, w_full;
    logic [39:0]        w_wt, w_wc;
    logic [40:0]        w_tot;
    logic [30:0]        w_nabs;
    logic [19:0]        w_cabs;
    logic [24:0]        w_p;

    assign w_in_acc = s_in.valid && s_in.ready;
    assign s_in.ready = (r_st == elrp_pkg::ST_IDLE) && !r_vld;
    assign s_cfg.ready = 1'b1;

    assign w_bit = r_ord[5'(r_ev - 5'd1 - r_k)];
    assign w_wt  = 40'(r_hr) * 40'(r_t);
    assign w_wc  = {8'd0, r_c, 16'd0};
    assign w_tot = {1'b0, w_wt} + {1'b0, w_wc};
    assign w_nabs = r_num[30] ? 31'(-r_num) : r_num;
    assign w_cabs = r_crit[19] ? 20'(-r_crit) : r_crit;
    // other term zero: the factor is exactly 1.0
    assign w_full = (w_bit ? w_wc : w_wt) == '0;
    // empty control group: p is exactly 1.0
    assign w_p = (r_c == '0) ? 25'h100_0000 : w_rsp.quo[24:0];

    elrp_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        n_st = r_st;
        w_req = '0;
        unique case (r_st)
            elrp_pkg::ST_IDLE: if (w_in_acc) n_st = elrp_pkg::ST_ORD;
            elrp_pkg::ST_ORD: begin
                if (r_bad) n_st = elrp_pkg::ST_OUT;
                else if (r_ord[OW-1] || (r_ord >> r_ev) != '0) n_st = elrp_pkg::ST_OUT;
                else n_st = elrp_pkg::ST_EVT;
            end
            elrp_pkg::ST_EVT: begin
                if (r_k == r_ev) n_st = elrp_pkg::ST_CMP1;
                else if ((w_bit ? w_wt : w_wc) == '0 || ({1'b0, r_t} + {1'b0, r_c}) == '0)
                    n_st = elrp_pkg::ST_NEXT;
                else begin
                    w_req.start = 1'b1;
                    w_req.num = 41'(r_t);
                    w_req.den = 41'({1'b0, r_t} + {1'b0, r_c});
                    w_req.frac_bits = 6'd24;
                    n_st = elrp_pkg::ST_P_WAIT;
                end
            end
            elrp_pkg::ST_P_WAIT: if (w_rsp.done) n_st = elrp_pkg::ST_F_START;
            elrp_pkg::ST_F_START: begin
                w_req.start = 1'b1;
                w_req.num = w_bit ? {1'b0, w_wt} : {1'b0, w_wc};
                w_req.den = w_tot;
                w_req.frac_bits = 6'd32;
                n_st = elrp_pkg::ST_F_WAIT;
            end
            elrp_pkg::ST_F_WAIT: if (w_rsp.done) n_st = elrp_pkg::ST_MUL;
            elrp_pkg::ST_MUL: n_st = elrp_pkg::ST_EVT;
            elrp_pkg::ST_CMP1: n_st = elrp_pkg::ST_CMP2;
            elrp_pkg::ST_CMP2: n_st = elrp_pkg::ST_CMP3;
            elrp_pkg::ST_CMP3: n_st = elrp_pkg::ST_ACC;
            elrp_pkg::ST_ACC: n_st = elrp_pkg::ST_NEXT;
            elrp_pkg::ST_NEXT: n_st = elrp_pkg::ST_ORD;
            elrp_pkg::ST_OUT: n_st = elrp_pkg::ST_IDLE;
            default: n_st = elrp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= elrp_pkg::ST_IDLE;
            r_vld  <= 1'b0;
            r_crit <= 20'sd128451;
            r_hr   <= 24'd65536;
        end else begin
            r_st <= n_st;
            if (s_cfg.valid) begin
                if (s_cfg.index == 1'(elrp_pkg::REG_CRIT)) r_crit <= s_cfg.data[19:0];
                else r_hr <= s_cfg.data;
            end
            if (r_st == elrp_pkg::ST_OUT) r_vld <= 1'b1;
            else if (m_out.ready) r_vld <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            elrp_pkg::ST_IDLE: if (w_in_acc) begin
                r_ev  <= s_in.event_count;
                r_n0  <= s_in.control_size;
                r_n1  <= s_in.treatment_size;
                r_bad <= (s_in.event_count > 5'(MAX_EVENTS))
                      || (17'(s_in.event_count) > 17'(s_in.control_size) + 17'(s_in.treatment_size));
                r_ord <= '0;
                r_acc <= '0;
            end
            elrp_pkg::ST_ORD: begin
                r_t <= r_n1; r_c <= r_n0; r_k <= '0;
                r_num <= '0; r_den <= '0; r_prob <= 33'h1_0000_0000;
                r_alive <= 1'b1;
            end
            elrp_pkg::ST_EVT: if (r_k != r_ev && n_st == elrp_pkg::ST_NEXT) r_alive <= 1'b0;
            elrp_pkg::ST_P_WAIT: if (w_rsp.done) begin
                r_p   <= w_p;
                r_num <= r_num + 31'({w_bit, 24'd0}) - 31'(w_p);
            end
            elrp_pkg::ST_F_START: r_mul <= 65'(r_p) * 65'(25'h100_0000 - r_p);
            elrp_pkg::ST_F_WAIT: if (w_rsp.done) begin
                r_den <= r_den + 31'(r_mul[48:24]);
                // a >= b gives a quotient of exactly 1.0 and leaves prob alone
                r_mul <= w_full ? 65'(r_prob) : 65'(r_prob) * 65'(w_rsp.quo[31:0]);
                r_gt  <= w_full;
            end
            elrp_pkg::ST_MUL: begin
                r_prob <= r_gt ? r_mul[32:0] : 33'(r_mul >> 32);
                if (w_bit) r_t <= r_t - 16'd1; else r_c <= r_c - 16'd1;
                r_k <= r_k + 5'd1;
            end
            elrp_pkg::ST_CMP1: begin
                r_lhs <= 71'(w_nabs) * 71'(w_nabs);
                r_c2  <= 40'(w_cabs) * 40'(w_cabs);
            end
            elrp_pkg::ST_CMP2: begin
                r_lhs <= {r_lhs[62:0], 8'd0};
                r_rhs <= 71'(r_c2) * 71'(r_den);
            end
            elrp_pkg::ST_CMP3: begin
                if (r_den == '0) r_gt <= 1'b0;
                else if (!r_crit[19]) r_gt <= !r_num[30] && r_num != '0 && r_lhs > r_rhs;
                else if (!r_num[30]) r_gt <= 1'b1;
                else r_gt <= r_lhs < r_rhs;
            end
            elrp_pkg::ST_ACC: if (r_alive && r_gt) r_acc <= r_acc + 50'(r_prob);
            elrp_pkg::ST_NEXT: r_ord <= r_ord + 1'b1;
            default: ;
        endcase
    end

    assign m_out.valid = r_vld;
    assign m_out.bad_arguments = r_bad;
    assign m_out.reject_probability = r_bad ? 32'd0 :
                                      (r_acc[49:32] != '0 ? 32'hFFFF_FFFF : r_acc[31:0]);

    ap_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != elrp_pkg::ST_IDLE) |-> !s_in.ready) else $error("ready while busy");
    ap_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == elrp_pkg::ST_OUT) |=> r_vld) else $error("result lost");
    ap_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_bad) |-> m_out.reject_probability == '0) else $error("bad nonzero");
endmodule

### dv/elrp_checker.sv
//------------------------------------------------------------------------------
// elrp_checker
// Watches the item, result and register channels of the logrank block. Predicts
// each result from its own copy of the registers and compares field by field.
//------------------------------------------------------------------------------
module elrp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    elrp_in_if   in_ch,
    elrp_out_if  out_ch,
    elrp_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] reject_probability;
        logic        bad_arguments;
    } t_result;

    t_result              result_q[$];
    logic signed [19:0]   crit_reg;
    logic [23:0]          hr_reg;

    // num/sqrt(den) > crit, done on squared integers
    function automatic bit stat_exceeds(longint num, longint unsigned den,
                                        logic signed [19:0] crit);
        longint unsigned nabs;
        longint unsigned cabs;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        nabs = (num < 0) ? longint'(-num) : longint'(num);
        cabs = (crit < 0) ? longint'(-longint'(crit)) : longint'(crit);
        lhs = 128'(nabs * nabs) << 8;
        rhs = 128'(cabs * cabs) * 128'(den);
        if (crit >= 0) return (num > 0) && (lhs > rhs);
        if (num >= 0) return 1'b1;
        return lhs < rhs;
    endfunction

    function automatic t_result predict_reject(logic [4:0] events, logic [15:0] n0,
                                               logic [15:0] n1);
        t_result         res;
        logic [63:0]     total;
        longint unsigned t, c, wt, wc, sel, p, den, f;
        longint          num;
        logic [127:0]    prob;
        bit              alive, tr;
        res = '0;
        total = '0;
        if (events > 16 || 32'(events) > 32'(n0) + 32'(n1)) begin
            res.bad_arguments = 1'b1;
            return res;
        end
        for (int i = 0; i < (1 << events); i++) begin
            t = 64'(n1); c = 64'(n0); den = 0; num = 0; prob = 128'(1) << 32; alive = 1'b1;
            for (int k = 0; k < events; k++) begin
                tr = 1'((i >> (events - 1 - k)) & 1);
                wt = longint'(hr_reg) * t;
                wc = c << 16;
                sel = tr ? wt : wc;
                if (sel == 0 || t + c == 0) begin
                    alive = 1'b0;
                    break;
                end
                p = (t << 24) / (t + c);
                num += (tr ? longint'(1 << 24) : 0) - longint'(p);
                den += (p * ((64'd1 << 24) - p)) >> 24;
                if (sel < wt + wc) begin
                    f = 64'((128'(sel) << 32) / 128'(wt + wc));
                    prob = (prob * 128'(f)) >> 32;
                end
                if (tr) t--; else c--;
            end
            if (alive && den > 0 && stat_exceeds(num, den, crit_reg))
                total += 64'(prob);
        end
        res.reject_probability = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        return res;
    endfunction

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            crit_reg     <= 20'sd128451;
            hr_reg       <= 24'd65536;
            o_fail_count <= 0;
            result_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == 1'(elrp_pkg::REG_CRIT)) crit_reg <= cfg_ch.data[19:0];
                else                                        hr_reg   <= cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready)
                result_q.push_back(predict_reject(in_ch.event_count, in_ch.control_size,
                                                  in_ch.treatment_size));
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result prob=%h bad=%b", $time,
                             out_ch.reject_probability, out_ch.bad_arguments);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = result_q.pop_front();
                    if (exp_res.reject_probability !== out_ch.reject_probability ||
                        exp_res.bad_arguments !== out_ch.bad_arguments) begin
                        $display("%0t: mismatch expected prob=%h bad=%b actual prob=%h bad=%b",
                                 $time, exp_res.reject_probability, exp_res.bad_arguments,
                                 out_ch.reject_probability, out_ch.bad_arguments);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### dv/tb_exact_logrank_rejection_prob.sv
//------------------------------------------------------------------------------
// tb_exact_logrank_rejection_prob
// Drives directed and random items through several register settings and idle
// patterns; the checker predicts and compares every result.
//------------------------------------------------------------------------------
module tb_exact_logrank_rejection_prob;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic [19:0] crit_set[6] = '{20'sd128451, -20'sd524288, 20'sd524287, 20'sd0,
                                 -20'sd128451, 20'sd65536};
    logic [23:0] hr_set[6]   = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd65536,
                                 24'd131072, 24'd32768};

    elrp_in_if  in_ch();
    elrp_out_if out_ch();
    elrp_cfg_if cfg_ch();

    exact_logrank_rejection_prob u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source),
        .s_cfg   (cfg_ch.sink)
    );

    elrp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(elrp_pkg::t_reg_idx idx, logic [23:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = 1'(idx);
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_item(logic [4:0] events, logic [15:0] n0, logic [15:0] n1);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid          = 1'b1;
        in_ch.event_count    = events;
        in_ch.control_size   = n0;
        in_ch.treatment_size = n1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [4:0]  ev;
        logic [15:0] n0, n1;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 85)      ev = 5'($urandom_range(5));
        else if (pick < 93) ev = 5'($urandom_range(7, 6));
        else                ev = 5'($urandom_range(31, 17));
        if ($urandom_range(9) < 7) begin
            n0 = 16'($urandom_range(12));
            n1 = 16'($urandom_range(12));
        end else begin
            n0 = 16'($urandom);
            n1 = 16'($urandom);
        end
        send_item(ev, n0, n1);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.event_count = '0;
        in_ch.control_size = '0;
        in_ch.treatment_size = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty groups, bad arguments, widest sizes, exhaustion
        send_item(5'd0, 16'd5, 16'd5);
        send_item(5'd0, 16'd0, 16'd0);
        send_item(5'd1, 16'd0, 16'd1);
        send_item(5'd1, 16'd1, 16'd0);
        send_item(5'd3, 16'd1, 16'd1);
        send_item(5'd2, 16'd0, 16'd0);
        send_item(5'd16, 16'd0, 16'd15);
        send_item(5'd17, 16'hFFFF, 16'hFFFF);
        send_item(5'd31, 16'd0, 16'd0);
        send_item(5'd5, 16'hFFFF, 16'hFFFF);
        send_item(5'd4, 16'd2, 16'd2);
        send_item(5'd6, 16'd3, 16'd10);
        send_item(5'd8, 16'hFFFF, 16'd0);
        send_item(5'd7, 16'd4, 16'd4);
        send_item(5'd9, 16'd20, 16'd20);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            // upper data bits of the critical value are don't-care; toggle them
            write_reg(elrp_pkg::REG_CRIT, {4'($urandom), crit_set[ph]});
            write_reg(elrp_pkg::REG_HR, (ph == 5) ? 24'($urandom) : hr_set[ph]);
            send_idle_pct  = (ph % 4 == 1) ? 61 : (ph % 4 == 3) ? 29 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 61 : (ph % 4 == 3) ? 29 : 0;
            for (int n = 0; n < 15; n++) begin
                // hold off until every result has arrived
                if (ph == 2 && n == 7) begin
                    @(negedge i_clk);
                    in_ch.valid = 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                send_random();
            end
            drain();
        end

        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
